// ===== rtl/cilp_pkg.sv =====
// Shared types and constants for the C integer literal parser.
`timescale 1ns / 1ps
`default_nettype none

package cilp_pkg;

	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 64;
	localparam int TYPE_W  = 2;
	localparam int DIGIT_W = 5;

	// Digit value for characters that are no digit in any radix.
	localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

	localparam logic [DIGIT_W-1:0] BASE_DEC = 5'd10;
	localparam logic [DIGIT_W-1:0] BASE_OCT = 5'd8;
	localparam logic [DIGIT_W-1:0] BASE_HEX = 5'd16;
	localparam logic [DIGIT_W-1:0] BASE_BIN = 5'd2;

	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_PREFIX = 2'd1,
		PH_DIGITS = 2'd2,
		PH_SUFFIX = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2,
		RX_BIN = 2'd3
	} radix_t;

	// Position inside the prefix: nothing, a leading zero, or a full radix mark.
	typedef enum logic [1:0] {
		POS_NONE = 2'd0,
		POS_ZERO = 2'd1,
		POS_MARK = 2'd2,
		POS_SPARE = 2'd3
	} position_t;

	typedef enum logic [3:0] {
		SF_NONE    = 4'd0,
		SF_L       = 4'd1,
		SF_LOW_L   = 4'd2,
		SF_LL      = 4'd3,
		SF_U       = 4'd4,
		SF_U_L     = 4'd5,
		SF_U_LOW_L = 4'd6,
		SF_DONE    = 4'd7
	} suffix_t;

	typedef enum logic [TYPE_W-1:0] {
		TY_INT   = 2'd0,
		TY_UINT  = 2'd1,
		TY_LONG  = 2'd2,
		TY_ULONG = 2'd3
	} type_code_t;

	function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = DIGIT_NONE;
		if (c >= "0" && c <= "9") d = DIGIT_W'(c - "0");
		else if (c >= "a" && c <= "f") d = DIGIT_W'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") d = DIGIT_W'(c - "A" + 8'd10);
		return d;
	endfunction

	function automatic logic [DIGIT_W-1:0] base_of(input radix_t r);
		logic [DIGIT_W-1:0] b;
		case (r)
			RX_DEC:  b = BASE_DEC;
			RX_OCT:  b = BASE_OCT;
			RX_HEX:  b = BASE_HEX;
			default: b = BASE_BIN;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cilp_if.sv =====
// Valid/ready channel interfaces for the character input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface cilp_in_if;
	logic                       valid;
	logic                       ready;
	logic [cilp_pkg::CHAR_W-1:0] character;
	logic                       last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

interface cilp_out_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic [cilp_pkg::VALUE_W-1:0] value;
	logic [cilp_pkg::TYPE_W-1:0]  type_code;

	modport source (output valid, output accepted, output value, output type_code, input ready);
	modport sink   (input valid, input accepted, input value, input type_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/c_integer_literal_parser_unit.sv =====
// Top level of the C integer literal parser: character register, parse state, result register.
//
//   channel   dir   payload                       request moves
//   token     in    character[7:0], last          one character of the token
//   result    out   accepted, value[63:0], type   one verdict per token
//
// One character per cycle unless a final character stalls: a request is registered, parsed
// by the radix multiply-add and suffix logic in the next cycle, and the verdict of a final
// character lands in the result register at the end of the cycle in which it moves on.
// Reset clears the parse state and both valid flags.
// A waiting result stalls only a final character and the characters behind it; other characters keep flowing.
`timescale 1ns / 1ps
`default_nettype none

module c_integer_literal_parser_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cilp_in_if.sink    token,
	cilp_out_if.source result
);
	import cilp_pkg::*;

	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              valid_s1;

	position_t         pos_q,   pos_n;
	radix_t            radix_q, radix_n;
	logic [VALUE_W-1:0] acc_q,  acc_n;
	phase_t            phase_q, phase_n;
	suffix_t           sfx_q,   sfx_n;
	logic              fail_q,  fail_n;

	logic              out_valid_q;
	logic              out_acc_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [TYPE_W-1:0] out_type_q;

	logic              out_free;
	logic              s1_go;

	logic [DIGIT_W-1:0] dig;
	logic              dig_ok;
	logic [VALUE_W+4:0] mac_w;
	logic [VALUE_W-1:0] mac;

	logic              up_l, low_l, uu;
	logic              sfx_bad;
	suffix_t           sfx_step;
	logic              do_sfx;

	logic              ok, has_l, has_u;
	type_code_t        ty;

	assign out_free    = !out_valid_q || result.ready;
	assign s1_go       = valid_s1 && (!last_s1 || out_free);
	assign token.ready = !valid_s1 || s1_go;

	assign dig    = digit_of(char_s1);
	assign dig_ok = dig < base_of(radix_q);

	// Multiply-add by the radix; anything that spills above 64 bits saturates.
	always_comb begin
		case (radix_q)
			RX_DEC:  mac_w = ({5'd0, acc_q} << 3) + ({5'd0, acc_q} << 1) + {64'd0, dig};
			RX_OCT:  mac_w = ({5'd0, acc_q} << 3) + {64'd0, dig};
			RX_HEX:  mac_w = ({5'd0, acc_q} << 4) + {64'd0, dig};
			default: mac_w = ({5'd0, acc_q} << 1) + {64'd0, dig};
		endcase
		mac = (|mac_w[VALUE_W+4:VALUE_W]) ? '1 : mac_w[VALUE_W-1:0];
	end

	// Suffix recognizer; the two letters of an LL pair must share their case.
	always_comb begin
		up_l     = (char_s1 == "L");
		low_l    = (char_s1 == "l");
		uu       = (char_s1 == "U") || (char_s1 == "u");
		sfx_bad  = 1'b1;
		sfx_step = sfx_q;
		case (sfx_q)
			SF_NONE: begin
				if (up_l) begin sfx_step = SF_L; sfx_bad = 1'b0; end
				else if (low_l) begin sfx_step = SF_LOW_L; sfx_bad = 1'b0; end
				else if (uu) begin sfx_step = SF_U; sfx_bad = 1'b0; end
			end
			SF_L: begin
				if (up_l) begin sfx_step = SF_LL; sfx_bad = 1'b0; end
				else if (uu) begin sfx_step = SF_DONE; sfx_bad = 1'b0; end
			end
			SF_LOW_L: begin
				if (low_l) begin sfx_step = SF_LL; sfx_bad = 1'b0; end
				else if (uu) begin sfx_step = SF_DONE; sfx_bad = 1'b0; end
			end
			SF_LL: begin
				if (uu) begin sfx_step = SF_DONE; sfx_bad = 1'b0; end
			end
			SF_U: begin
				if (up_l) begin sfx_step = SF_U_L; sfx_bad = 1'b0; end
				else if (low_l) begin sfx_step = SF_U_LOW_L; sfx_bad = 1'b0; end
			end
			SF_U_L: begin
				if (up_l) begin sfx_step = SF_DONE; sfx_bad = 1'b0; end
			end
			SF_U_LOW_L: begin
				if (low_l) begin sfx_step = SF_DONE; sfx_bad = 1'b0; end
			end
			default: begin
				sfx_bad = 1'b1;
			end
		endcase
	end

	// Next parse state for the registered character.
	always_comb begin
		pos_n   = pos_q;
		radix_n = radix_q;
		acc_n   = acc_q;
		phase_n = phase_q;
		sfx_n   = sfx_q;
		fail_n  = fail_q;
		do_sfx  = 1'b0;
		if (!fail_q) begin
			case (phase_q)
				PH_START: begin
					if (char_s1 == "0") begin
						phase_n = PH_PREFIX;
						pos_n   = POS_ZERO;
						radix_n = RX_OCT;
						acc_n   = '0;
					end else if (char_s1 >= "1" && char_s1 <= "9") begin
						phase_n = PH_DIGITS;
						radix_n = RX_DEC;
						acc_n   = VALUE_W'(dig);
					end else begin
						fail_n = 1'b1;
					end
				end
				PH_PREFIX: begin
					if (pos_q == POS_ZERO) begin
						if (char_s1 == "x" || char_s1 == "X") begin
							pos_n   = POS_MARK;
							radix_n = RX_HEX;
						end else if (char_s1 == "b" || char_s1 == "B") begin
							pos_n   = POS_MARK;
							radix_n = RX_BIN;
						end else if (dig < BASE_OCT) begin
							phase_n = PH_DIGITS;
							acc_n   = VALUE_W'(dig);
						end else if (dig < BASE_DEC) begin
							fail_n = 1'b1;
						end else begin
							do_sfx = 1'b1;
						end
					end else if (dig_ok) begin
						phase_n = PH_DIGITS;
						acc_n   = VALUE_W'(dig);
					end else begin
						fail_n = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (dig_ok) acc_n = mac;
					else do_sfx = 1'b1;
				end
				default: begin
					do_sfx = 1'b1;
				end
			endcase
		end
		if (do_sfx) begin
			phase_n = PH_SUFFIX;
			if (sfx_bad) fail_n = 1'b1;
			else sfx_n = sfx_step;
		end
	end

	// Verdict and type for a token that ends with this character.
	always_comb begin
		ok    = !fail_n && (phase_n != PH_START) &&
		        !(phase_n == PH_PREFIX && pos_n == POS_MARK);
		has_l = (sfx_n == SF_L) || (sfx_n == SF_LOW_L) || (sfx_n == SF_LL) ||
		        (sfx_n == SF_U_L) || (sfx_n == SF_U_LOW_L) || (sfx_n == SF_DONE);
		has_u = (sfx_n == SF_U) || (sfx_n == SF_U_L) || (sfx_n == SF_U_LOW_L) ||
		        (sfx_n == SF_DONE);
		if (has_l && has_u) ty = TY_ULONG;
		else if (radix_n == RX_DEC) begin
			if (has_l) ty = TY_LONG;
			else if (has_u) ty = (|acc_n[63:32]) ? TY_ULONG : TY_UINT;
			else ty = (|acc_n[63:31]) ? TY_LONG : TY_INT;
		end else begin
			if (has_l) ty = acc_n[63] ? TY_ULONG : TY_LONG;
			else if (has_u) ty = (|acc_n[63:32]) ? TY_ULONG : TY_UINT;
			else if (acc_n[63]) ty = TY_ULONG;
			else if (|acc_n[62:32]) ty = TY_LONG;
			else if (acc_n[31]) ty = TY_UINT;
			else ty = TY_INT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (token.valid && token.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (token.valid && token.ready) begin
			char_s1 <= token.character;
			last_s1 <= token.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_NONE;
			radix_q <= RX_DEC;
			acc_q   <= '0;
			phase_q <= PH_START;
			sfx_q   <= SF_NONE;
			fail_q  <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				pos_q   <= POS_NONE;
				radix_q <= RX_DEC;
				acc_q   <= '0;
				phase_q <= PH_START;
				sfx_q   <= SF_NONE;
				fail_q  <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				radix_q <= radix_n;
				acc_q   <= acc_n;
				phase_q <= phase_n;
				sfx_q   <= sfx_n;
				fail_q  <= fail_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			out_acc_q   <= ok;
			out_value_q <= ok ? acc_n : '0;
			out_type_q  <= ok ? ty : TY_INT;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.accepted  = out_acc_q;
	assign result.value     = out_value_q;
	assign result.type_code = out_type_q;

endmodule

`default_nettype wire

// ===== dv/literal_verdict_checker.sv =====
// Checker for the C integer literal parser: predicts each token's verdict and compares results.
`timescale 1ns / 1ps

module literal_verdict_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	cilp_in_if        tok,
	cilp_out_if       res,
	output int        mismatches,
	output int        outstanding,
	output int        verdicts_seen,
	output int        accepted_seen
);
	import cilp_pkg::*;

	typedef struct packed {
		logic               accepted;
		logic [VALUE_W-1:0] value;
		type_code_t         ty;
	} verdict_t;

	verdict_t pending_verdicts[$];

	// Shadow copy of the parse state.
	position_t          pos;
	radix_t             rdx;
	logic [VALUE_W-1:0] acc;
	phase_t             ph;
	suffix_t            sfx;
	bit                 bad;

	function automatic logic [4:0] char_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
		return 5'd16;
	endfunction

	function automatic logic [4:0] radix_base(input radix_t r);
		case (r)
			RX_DEC:  return 5'd10;
			RX_OCT:  return 5'd8;
			RX_HEX:  return 5'd16;
			default: return 5'd2;
		endcase
	endfunction

	function automatic void clear_parse();
		pos = POS_NONE;
		rdx = RX_DEC;
		acc = '0;
		ph  = PH_START;
		sfx = SF_NONE;
		bad = 1'b0;
	endfunction

	// Multiply-add that sticks at all ones once the value no longer fits.
	function automatic void push_digit(input logic [4:0] d);
		logic [VALUE_W-1:0] b;
		logic [VALUE_W-1:0] limit;
		b = VALUE_W'(radix_base(rdx));
		limit = ({VALUE_W{1'b1}} - VALUE_W'(d)) / b;
		if (acc > limit) acc = '1;
		else acc = acc * b + VALUE_W'(d);
	endfunction

	function automatic void take_suffix(input logic [7:0] c);
		suffix_t nxt;
		bit      ok;
		bit      up_l;
		bit      low_l;
		bit      uu;
		up_l  = (c == "L");
		low_l = (c == "l");
		uu    = (c == "U" || c == "u");
		ph  = PH_SUFFIX;
		ok  = 1'b1;
		nxt = SF_NONE;
		case (sfx)
			SF_NONE: begin
				if (up_l) nxt = SF_L;
				else if (low_l) nxt = SF_LOW_L;
				else if (uu) nxt = SF_U;
				else ok = 1'b0;
			end
			SF_L: begin
				if (up_l) nxt = SF_LL;
				else if (uu) nxt = SF_DONE;
				else ok = 1'b0;
			end
			SF_LOW_L: begin
				if (low_l) nxt = SF_LL;
				else if (uu) nxt = SF_DONE;
				else ok = 1'b0;
			end
			SF_LL: begin
				if (uu) nxt = SF_DONE;
				else ok = 1'b0;
			end
			SF_U: begin
				if (up_l) nxt = SF_U_L;
				else if (low_l) nxt = SF_U_LOW_L;
				else ok = 1'b0;
			end
			SF_U_L: begin
				if (up_l) nxt = SF_DONE;
				else ok = 1'b0;
			end
			SF_U_LOW_L: begin
				if (low_l) nxt = SF_DONE;
				else ok = 1'b0;
			end
			default: ok = 1'b0;
		endcase
		if (!ok) bad = 1'b1;
		else sfx = nxt;
	endfunction

	function automatic void step_char(input logic [7:0] c);
		logic [4:0] d;
		d = char_digit(c);
		if (bad) return;
		case (ph)
			PH_START: begin
				if (c == "0") begin
					ph  = PH_PREFIX;
					pos = POS_ZERO;
					rdx = RX_OCT;
					acc = '0;
				end else if (c >= "1" && c <= "9") begin
					ph  = PH_DIGITS;
					rdx = RX_DEC;
					acc = VALUE_W'(d);
				end else begin
					bad = 1'b1;
				end
			end
			PH_PREFIX: begin
				if (pos == POS_ZERO) begin
					if (c == "x" || c == "X") begin
						pos = POS_MARK;
						rdx = RX_HEX;
					end else if (c == "b" || c == "B") begin
						pos = POS_MARK;
						rdx = RX_BIN;
					end else if (d < 5'd8) begin
						ph  = PH_DIGITS;
						acc = VALUE_W'(d);
					end else if (d < 5'd10) begin
						bad = 1'b1;
					end else begin
						take_suffix(c);
					end
				end else if (d < radix_base(rdx)) begin
					ph  = PH_DIGITS;
					acc = VALUE_W'(d);
				end else begin
					bad = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (d < radix_base(rdx)) push_digit(d);
				else take_suffix(c);
			end
			default: take_suffix(c);
		endcase
	endfunction

	function automatic verdict_t close_token();
		verdict_t   v;
		bit         has_l;
		bit         has_u;
		type_code_t ty;
		has_l = (sfx inside {SF_L, SF_LOW_L, SF_LL, SF_U_L, SF_U_LOW_L, SF_DONE});
		has_u = (sfx inside {SF_U, SF_U_L, SF_U_LOW_L, SF_DONE});
		if (has_l && has_u) ty = TY_ULONG;
		else if (rdx == RX_DEC) begin
			if (has_l) ty = TY_LONG;
			else if (has_u) ty = (acc[63:32] != 0) ? TY_ULONG : TY_UINT;
			else ty = (acc[63:31] != 0) ? TY_LONG : TY_INT;
		end else begin
			if (has_l) ty = acc[63] ? TY_ULONG : TY_LONG;
			else if (has_u) ty = (acc[63:32] != 0) ? TY_ULONG : TY_UINT;
			else if (acc[63]) ty = TY_ULONG;
			else if (acc[63:32] != 0) ty = TY_LONG;
			else if (acc[63:31] != 0) ty = TY_UINT;
			else ty = TY_INT;
		end
		v.accepted = !bad && ph != PH_START && !(ph == PH_PREFIX && pos == POS_MARK);
		v.value    = v.accepted ? acc : '0;
		v.ty       = v.accepted ? ty : TY_INT;
		clear_parse();
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		// Keep the log short if the block is badly broken.
		if (mismatches <= 40)
			$display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			clear_parse();
			pending_verdicts.delete();
			mismatches    = 0;
			outstanding   = 0;
			verdicts_seen = 0;
			accepted_seen = 0;
		end else begin
			if (tok.valid && tok.ready) begin
				step_char(tok.character);
				if (tok.last) pending_verdicts.push_back(close_token());
			end
			if (res.valid && res.ready) begin
				got.accepted = res.accepted;
				got.value    = res.value;
				got.ty       = type_code_t'(res.type_code);
				verdicts_seen++;
				if (got.accepted) accepted_seen++;
				if (pending_verdicts.size() == 0) begin
					report_mismatch("unrequested result", 64'(got.value), '0);
				end else begin
					want = pending_verdicts.pop_front();
					if (got.accepted !== want.accepted)
						report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
					if (got.value !== want.value)
						report_mismatch("value", got.value, want.value);
					if (got.ty !== want.ty)
						report_mismatch("type_code", 64'(got.ty), 64'(want.ty));
				end
			end
			outstanding = pending_verdicts.size();
		end
	end

endmodule

// ===== dv/c_integer_literal_parser_unit_tb.sv =====
// Testbench top for the C integer literal parser: clock, reset, token stimulus and verdict.
`timescale 1ns / 1ps

module c_integer_literal_parser_unit_tb;
	import cilp_pkg::*;

	logic clk;
	logic arst_n;
	bit   calm;

	int mismatches;
	int outstanding;
	int verdicts_seen;
	int accepted_seen;
	int tokens_sent;
	int chars_sent;

	logic [7:0] token_chars[$];

	string directed_tokens[26] = '{
		"0", "7", "123", "0x1F", "0XffU", "0b101", "0B2", "0777", "09", "0x", "0xg",
		"0x0x1", "-1", " 1", "L", "18446744073709551616", "0xFFFFFFFFFFFFFFFF0",
		"2147483648", "4294967296u", "0x80000000", "0x8000000000000000l", "123LLU",
		"9ull", "1lL", "1uLx", "0L"
	};
	string good_suffixes[23] = '{
		"", "L", "l", "U", "u", "LL", "ll", "lu", "lU", "Lu", "LU", "ul", "uL", "Ul", "UL",
		"LLU", "LLu", "llU", "llu", "ULL", "Ull", "uLL", "ull"
	};
	string bad_suffixes[9] = '{"lL", "Ll", "uu", "LLL", "UU", "LUL", "uLl", "lul", "q"};
	string prefix_traps[7] = '{"0x", "0b", "0X", "0B", "0x0x1F", "0b2", "0xz"};

	cilp_in_if  tok_ch ();
	cilp_out_if res_ch ();

	c_integer_literal_parser_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.token  (tok_ch),
		.result (res_ch)
	);

	literal_verdict_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok           (tok_ch),
		.res           (res_ch),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.verdicts_seen (verdicts_seen),
		.accepted_seen (accepted_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// Mostly back to back, often a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic load_text(input string s);
		token_chars.delete();
		for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
	endtask

	task automatic send_token();
		int g;
		foreach (token_chars[i]) begin
			tok_ch.valid     <= 1'b1;
			tok_ch.character <= token_chars[i];
			tok_ch.last      <= (i == token_chars.size() - 1);
			do @(posedge clk); while (!tok_ch.ready);
			g = pick_gap();
			if (g > 0) begin
				tok_ch.valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		chars_sent += token_chars.size();
		tokens_sent++;
	endtask

	// A well-formed literal in a random radix, either with random digits or with a random,
	// all-ones or near-boundary value, followed by a mostly legal suffix.
	task automatic build_literal();
		radix_t      rdx;
		logic [63:0] v;
		logic [63:0] d;
		logic [63:0] base;
		logic [7:0]  digs[$];
		int          ndig;
		int          k;
		bit          upper;
		string       hex_set;
		string       sfx;
		hex_set = "0123456789abcdefABCDEF";
		rdx = radix_t'($urandom_range(0, 3));
		upper = $urandom_range(0, 1);
		case (rdx)
			RX_OCT:  load_text("0");
			RX_HEX:  load_text(upper ? "0X" : "0x");
			RX_BIN:  load_text(upper ? "0B" : "0b");
			default: token_chars.delete();
		endcase
		if ($urandom_range(0, 1)) begin
			if ($urandom_range(0, 9) == 0)
				ndig = (rdx == RX_BIN) ? $urandom_range(60, 68) : $urandom_range(15, 24);
			else
				ndig = $urandom_range(1, 6);
			for (k = 0; k < ndig; k++) begin
				case (rdx)
					RX_DEC: begin
						if (k == 0) token_chars.push_back(8'("1" + $urandom_range(0, 8)));
						else token_chars.push_back(8'("0" + $urandom_range(0, 9)));
					end
					RX_OCT:  token_chars.push_back(8'("0" + $urandom_range(0, 7)));
					RX_HEX:  token_chars.push_back(hex_set[$urandom_range(0, 21)]);
					default: token_chars.push_back(8'("0" + $urandom_range(0, 1)));
				endcase
			end
		end else begin
			case ($urandom_range(0, 3))
				0: v = {$urandom, $urandom};
				1: v = '1;
				default: begin
					k = ($urandom_range(0, 2) == 0) ? 63 : 31 + $urandom_range(0, 1);
					v = (64'd1 << k) - 64'd2 + 64'($urandom_range(0, 4));
				end
			endcase
			case (rdx)
				RX_DEC:  base = 64'd10;
				RX_OCT:  base = 64'd8;
				RX_HEX:  base = 64'd16;
				default: base = 64'd2;
			endcase
			digs.delete();
			do begin
				d = v % base;
				v = v / base;
				if (d < 64'd10) digs.push_front(8'("0" + d));
				else digs.push_front(8'((upper ? "A" : "a") + d - 64'd10));
			end while (v != 0);
			foreach (digs[i]) token_chars.push_back(digs[i]);
		end
		k = $urandom_range(0, 99);
		if (k < 10) sfx = bad_suffixes[$urandom_range(0, 8)];
		else if (k < 45) sfx = "";
		else sfx = good_suffixes[$urandom_range(0, 22)];
		for (k = 0; k < sfx.len(); k++) token_chars.push_back(sfx[k]);
	endtask

	// Result side: bursts of readiness broken by stalls of random length.
	initial begin
		int g;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			g = pick_gap();
			if (g > 0) begin
				res_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	initial begin
		int    pick;
		int    at;
		string marks;
		marks = "xXbB89Lu+- .0";
		calm = 1'b0;
		tokens_sent = 0;
		chars_sent = 0;
		arst_n           <= 1'b0;
		tok_ch.valid     <= 1'b0;
		tok_ch.character <= '0;
		tok_ch.last      <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tokens[i]) begin
			load_text(directed_tokens[i]);
			send_token();
		end

		while (chars_sent < 1850) begin
			if (tokens_sent % 40 == 0) calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				build_literal();
			end else if (pick < 82) begin
				// Damage one character of an otherwise legal literal.
				build_literal();
				at = $urandom_range(0, token_chars.size() - 1);
				if ($urandom_range(0, 1)) token_chars[at] = marks[$urandom_range(0, marks.len() - 1)];
				else token_chars[at] = 8'($urandom_range(0, 255));
			end else if (pick < 88) begin
				load_text(prefix_traps[$urandom_range(0, 6)]);
			end else begin
				token_chars.delete();
				repeat ($urandom_range(1, 6)) token_chars.push_back(8'($urandom_range(0, 255)));
			end
			send_token();
		end
		tok_ch.valid <= 1'b0;

		// The checker records the final request at the edge just passed.
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Drove %0d tokens (%0d characters), directed cases first, then random ones.",
			tokens_sent, chars_sent);
		$display("Checked %0d verdicts, %0d of them accepted literals.",
			verdicts_seen, accepted_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cilp_pkg.sv
rtl/cilp_if.sv
rtl/c_integer_literal_parser_unit.sv
dv/literal_verdict_checker.sv
dv/c_integer_literal_parser_unit_tb.sv
